// File: src/crsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cashless reader session package
// Shared codes, reset values, transaction types and the session move table.
// ----------------------------------------------------------------------------
package crsf_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	// Decoded bus function codes.
	localparam logic [3:0] FN_RESET     = 4'd0;
	localparam logic [3:0] FN_POLL      = 4'd1;
	localparam logic [3:0] FN_SETUP_CFG = 4'd2;
	localparam logic [3:0] FN_SETUP_PRC = 4'd3;
	localparam logic [3:0] FN_VEND_REQ  = 4'd4;
	localparam logic [3:0] FN_VEND_CANC = 4'd5;
	localparam logic [3:0] FN_VEND_SUCC = 4'd6;
	localparam logic [3:0] FN_VEND_FAIL = 4'd7;
	localparam logic [3:0] FN_SESS_DONE = 4'd8;
	localparam logic [3:0] FN_CASH_SALE = 4'd9;
	localparam logic [3:0] FN_DISABLE   = 4'd10;
	localparam logic [3:0] FN_ENABLE    = 4'd11;
	localparam logic [3:0] FN_RDR_CANC  = 4'd12;
	localparam logic [3:0] FN_REQ_ID    = 4'd13;
	localparam logic [3:0] FN_FUNDS     = 4'd14;

	// Internal operation classes produced by the front end.
	localparam logic [3:0] OP_RESET   = 4'd0;
	localparam logic [3:0] OP_POLL    = 4'd1;
	localparam logic [3:0] OP_CFG     = 4'd2;
	localparam logic [3:0] OP_PRICES  = 4'd3;
	localparam logic [3:0] OP_VREQ    = 4'd4;
	localparam logic [3:0] OP_NACK    = 4'd5;
	localparam logic [3:0] OP_VSUCC   = 4'd6;
	localparam logic [3:0] OP_SDONE   = 4'd7;
	localparam logic [3:0] OP_DISABLE = 4'd8;
	localparam logic [3:0] OP_ENABLE  = 4'd9;
	localparam logic [3:0] OP_RCANCEL = 4'd10;
	localparam logic [3:0] OP_ID      = 4'd11;
	localparam logic [3:0] OP_FUNDS   = 4'd12;
	localparam logic [3:0] OP_NONE    = 4'd13;

	// Session states.
	localparam logic [2:0] ST_INACTIVE = 3'd0;
	localparam logic [2:0] ST_DISABLED = 3'd1;
	localparam logic [2:0] ST_ENABLED  = 3'd2;
	localparam logic [2:0] ST_IDLE     = 3'd3;
	localparam logic [2:0] ST_VEND     = 3'd4;

	// Response codes.
	localparam logic [3:0] RC_ACK     = 4'd0;
	localparam logic [3:0] RC_NACK    = 4'd1;
	localparam logic [3:0] RC_OOS     = 4'd2;
	localparam logic [3:0] RC_JUSTRST = 4'd3;
	localparam logic [3:0] RC_CONFIG  = 4'd4;
	localparam logic [3:0] RC_BEGIN   = 4'd5;
	localparam logic [3:0] RC_CANCREQ = 4'd6;
	localparam logic [3:0] RC_CANCEL  = 4'd7;
	localparam logic [3:0] RC_APPROVE = 4'd8;
	localparam logic [3:0] RC_ENDSESS = 4'd9;
	localparam logic [3:0] RC_PERIPH  = 4'd10;
	localparam logic [3:0] RC_NONE    = 4'd11;

	// Configuration register indexes.
	localparam logic [2:0] REG_FEATURE  = 3'd0;
	localparam logic [2:0] REG_COUNTRY  = 3'd1;
	localparam logic [2:0] REG_SCALE    = 3'd2;
	localparam logic [2:0] REG_DECIMALS = 3'd3;
	localparam logic [2:0] REG_MAX_RESP = 3'd4;
	localparam logic [2:0] REG_OPTIONS  = 3'd5;

	localparam logic [7:0]  RST_FEATURE  = 8'd1;
	localparam logic [15:0] RST_COUNTRY  = 16'h1036;
	localparam logic [7:0]  RST_SCALE    = 8'd2;
	localparam logic [7:0]  RST_DECIMALS = 8'd2;
	localparam logic [7:0]  RST_MAX_RESP = 8'd10;
	localparam logic [7:0]  RST_OPTIONS  = 8'b0000_0110;

	localparam logic [15:0] APPROVED_AMOUNT = 16'hFFFF;

	// Reader configuration, feature level in the lowest bits.
	typedef struct packed {
		logic [7:0]  option_bits;
		logic [7:0]  max_response_seconds;
		logic [7:0]  decimal_places;
		logic [7:0]  scale_factor;
		logic [15:0] country_code;
		logic [7:0]  reader_level;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] funds_value;
	} cmd_t;

	typedef struct packed {
		logic [15:0] funds_now;
		logic [2:0]  session_state;
		logic [55:0] payload;
		logic [3:0]  response_length;
		logic [3:0]  response_code;
	} rsp_t;

	function automatic logic move_allowed(input logic [2:0] from_st, input logic [2:0] to_st);
		logic ok;
		ok = 1'b0;
		case (from_st)
			ST_INACTIVE: ok = (to_st == ST_DISABLED);
			ST_DISABLED: ok = (to_st == ST_INACTIVE) || (to_st == ST_ENABLED);
			ST_ENABLED:  ok = (to_st == ST_INACTIVE) || (to_st == ST_DISABLED) ||
			                  (to_st == ST_IDLE);
			ST_IDLE:     ok = (to_st == ST_INACTIVE) || (to_st == ST_DISABLED) ||
			                  (to_st == ST_ENABLED) || (to_st == ST_VEND);
			ST_VEND:     ok = (to_st == ST_INACTIVE) || (to_st == ST_IDLE);
			default:     ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// File: src/cashless_reader_session_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cashless reader session machine
// Peripheral side of a vending-bus cashless reader: command decode, command
// queue, session state machine and reader configuration registers.
// ----------------------------------------------------------------------------
// The block takes one decoded bus command or funds-available event per clock
// while the command queue has room, and returns exactly one response
// transaction for each. An accepted command passes through the command queue
// and the response output register; throughput is one transaction per cycle
// while the output is not stalled. A two-entry command queue sits between the
// decoder and the session machine, and the response is held in an output
// register, so the input accepts up to two further transactions while a
// response waits. Configuration registers sit at byte addresses 0, 4, 8, 12,
// 16 and 20 and should be written only while no transaction is in flight.
module cashless_reader_session_fsm #(
	parameter int unsigned QUEUE_DEPTH = crsf_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // funds_value[15:0]
	input  logic [3:0]  s_tuser,   // func[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// response_length[3:0], payload[59:4], session_state[62:60],
	// funds_now[78:63], zero fill[79]
	output logic [79:0] m_tdata,
	output logic [3:0]  m_tuser,   // response_code[3:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	crsf_pkg::cfg_t cfg_q;
	crsf_pkg::cmd_t push_data;
	crsf_pkg::cmd_t pop_data;
	crsf_pkg::rsp_t rsp;
	logic           push_valid;
	logic           push_ready;
	logic           pop_valid;
	logic           pop_ready;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reader_level         <= crsf_pkg::RST_FEATURE;
			cfg_q.country_code         <= crsf_pkg::RST_COUNTRY;
			cfg_q.scale_factor         <= crsf_pkg::RST_SCALE;
			cfg_q.decimal_places       <= crsf_pkg::RST_DECIMALS;
			cfg_q.max_response_seconds <= crsf_pkg::RST_MAX_RESP;
			cfg_q.option_bits          <= crsf_pkg::RST_OPTIONS;
		end else if (wr_en) begin
			case (reg_idx)
				crsf_pkg::REG_FEATURE:  cfg_q.reader_level         <= pwdata[7:0];
				crsf_pkg::REG_COUNTRY:  cfg_q.country_code         <= pwdata[15:0];
				crsf_pkg::REG_SCALE:    cfg_q.scale_factor         <= pwdata[7:0];
				crsf_pkg::REG_DECIMALS: cfg_q.decimal_places       <= pwdata[7:0];
				crsf_pkg::REG_MAX_RESP: cfg_q.max_response_seconds <= pwdata[7:0];
				crsf_pkg::REG_OPTIONS:  cfg_q.option_bits          <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			crsf_pkg::REG_FEATURE:  prdata = {24'd0, cfg_q.reader_level};
			crsf_pkg::REG_COUNTRY:  prdata = {16'd0, cfg_q.country_code};
			crsf_pkg::REG_SCALE:    prdata = {24'd0, cfg_q.scale_factor};
			crsf_pkg::REG_DECIMALS: prdata = {24'd0, cfg_q.decimal_places};
			crsf_pkg::REG_MAX_RESP: prdata = {24'd0, cfg_q.max_response_seconds};
			crsf_pkg::REG_OPTIONS:  prdata = {24'd0, cfg_q.option_bits};
			default:                prdata = '0;
		endcase
	end

	crsf_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	crsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	crsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.rsp       (rsp)
	);

	assign m_tuser = rsp.response_code;
	assign m_tdata = {1'b0, rsp.funds_now, rsp.session_state, rsp.payload, rsp.response_length};

endmodule

// File: src/crsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cashless reader front end
// Accepts input transactions and classifies each bus function into an
// operation class for the command queue.
// ----------------------------------------------------------------------------
module crsf_front (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,    // funds_value
	input  logic [3:0]         s_tuser,    // func
	output logic               push_valid,
	input  logic               push_ready,
	output crsf_pkg::cmd_t     push_data
);

	logic [3:0] op;

	always_comb begin
		case (s_tuser)
			crsf_pkg::FN_RESET:     op = crsf_pkg::OP_RESET;
			crsf_pkg::FN_POLL:      op = crsf_pkg::OP_POLL;
			crsf_pkg::FN_SETUP_CFG: op = crsf_pkg::OP_CFG;
			crsf_pkg::FN_SETUP_PRC: op = crsf_pkg::OP_PRICES;
			crsf_pkg::FN_VEND_REQ:  op = crsf_pkg::OP_VREQ;
			crsf_pkg::FN_VEND_CANC: op = crsf_pkg::OP_NACK;
			crsf_pkg::FN_VEND_SUCC: op = crsf_pkg::OP_VSUCC;
			crsf_pkg::FN_VEND_FAIL: op = crsf_pkg::OP_NACK;
			crsf_pkg::FN_SESS_DONE: op = crsf_pkg::OP_SDONE;
			crsf_pkg::FN_CASH_SALE: op = crsf_pkg::OP_NACK;
			crsf_pkg::FN_DISABLE:   op = crsf_pkg::OP_DISABLE;
			crsf_pkg::FN_ENABLE:    op = crsf_pkg::OP_ENABLE;
			crsf_pkg::FN_RDR_CANC:  op = crsf_pkg::OP_RCANCEL;
			crsf_pkg::FN_REQ_ID:    op = crsf_pkg::OP_ID;
			crsf_pkg::FN_FUNDS:     op = crsf_pkg::OP_FUNDS;
			default:                op = crsf_pkg::OP_NONE;
		endcase
	end

	assign s_tready              = push_ready;
	assign push_valid            = s_tvalid;
	assign push_data.op          = op;
	assign push_data.funds_value = s_tdata;

endmodule

// File: src/crsf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cashless reader command queue
// Short first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
module crsf_queue #(
	parameter int unsigned DEPTH = crsf_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  crsf_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output crsf_pkg::cmd_t pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	crsf_pkg::cmd_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/crsf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cashless reader back end
// Executes one queued command per cycle unless the output stalls, against the
// session state, and holds the response in an output register until taken.
// ----------------------------------------------------------------------------
module crsf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  crsf_pkg::cfg_t cfg,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  crsf_pkg::cmd_t pop_data,
	output logic           m_tvalid,
	input  logic           m_tready,
	output crsf_pkg::rsp_t rsp
);

	logic [2:0]     st_q;
	logic           cfg_seen_q;
	logic           prc_seen_q;
	logic           end_pend_q;
	logic           dis_after_q;
	logic [15:0]    funds_q;
	logic           out_valid_q;
	crsf_pkg::rsp_t rsp_q;

	logic [2:0]     target;
	logic           go;
	logic [2:0]     st_n;
	logic           cfg_seen_n;
	logic           prc_seen_n;
	logic           end_pend_n;
	logic           dis_after_n;
	logic [15:0]    funds_n;
	logic [3:0]     code;
	logic [3:0]     len;
	logic [55:0]    payload;
	logic           take;

	assign take      = pop_valid && (!out_valid_q || m_tready);
	assign pop_ready = !out_valid_q || m_tready;

	always_comb begin
		target      = st_q;
		go          = 1'b0;
		cfg_seen_n  = cfg_seen_q;
		prc_seen_n  = prc_seen_q;
		end_pend_n  = end_pend_q;
		dis_after_n = dis_after_q;
		funds_n     = funds_q;
		code        = crsf_pkg::RC_NONE;
		len         = 4'd0;
		payload     = '0;
		case (pop_data.op)
			crsf_pkg::OP_RESET: begin
				target     = crsf_pkg::ST_INACTIVE;
				go         = 1'b1;
				cfg_seen_n = 1'b0;
				prc_seen_n = 1'b0;
				code       = crsf_pkg::RC_ACK;
			end
			crsf_pkg::OP_POLL: begin
				if (st_q == crsf_pkg::ST_INACTIVE) begin
					code = crsf_pkg::RC_JUSTRST;
					len  = 4'd1;
				end else if (st_q == crsf_pkg::ST_ENABLED && funds_q != '0) begin
					code    = crsf_pkg::RC_BEGIN;
					len     = 4'd3;
					payload = {40'd0, funds_q};
					target  = crsf_pkg::ST_IDLE;
					go      = 1'b1;
				end else if (st_q == crsf_pkg::ST_IDLE && end_pend_q) begin
					code = crsf_pkg::RC_CANCREQ;
					len  = 4'd1;
				end else begin
					code = crsf_pkg::RC_ACK;
				end
			end
			crsf_pkg::OP_CFG: begin
				cfg_seen_n = 1'b1;
				target     = prc_seen_q ? crsf_pkg::ST_DISABLED : crsf_pkg::ST_INACTIVE;
				go         = 1'b1;
				code       = crsf_pkg::RC_CONFIG;
				len        = 4'd8;
				payload    = cfg;
			end
			crsf_pkg::OP_PRICES: begin
				prc_seen_n = 1'b1;
				target     = cfg_seen_q ? crsf_pkg::ST_DISABLED : crsf_pkg::ST_INACTIVE;
				go         = 1'b1;
				code       = crsf_pkg::RC_ACK;
			end
			crsf_pkg::OP_VREQ: begin
				if (st_q != crsf_pkg::ST_IDLE) begin
					code = crsf_pkg::RC_OOS;
					len  = 4'd1;
				end else begin
					code    = crsf_pkg::RC_APPROVE;
					len     = 4'd3;
					payload = {40'd0, crsf_pkg::APPROVED_AMOUNT};
					target  = crsf_pkg::ST_VEND;
					go      = 1'b1;
				end
			end
			crsf_pkg::OP_NACK: begin
				code = crsf_pkg::RC_NACK;
			end
			crsf_pkg::OP_VSUCC: begin
				target = crsf_pkg::ST_IDLE;
				go     = 1'b1;
				code   = crsf_pkg::RC_ACK;
			end
			crsf_pkg::OP_SDONE: begin
				target      = dis_after_q ? crsf_pkg::ST_DISABLED : crsf_pkg::ST_ENABLED;
				go          = 1'b1;
				dis_after_n = 1'b0;
				end_pend_n  = 1'b0;
				code        = crsf_pkg::RC_ENDSESS;
				len         = 4'd1;
			end
			crsf_pkg::OP_DISABLE: begin
				if (st_q != crsf_pkg::ST_VEND) begin
					target = crsf_pkg::ST_DISABLED;
					go     = 1'b1;
				end else begin
					dis_after_n = 1'b1;
				end
				code = crsf_pkg::RC_ACK;
			end
			crsf_pkg::OP_ENABLE: begin
				if (st_q == crsf_pkg::ST_DISABLED && cfg_seen_q && prc_seen_q) begin
					target      = crsf_pkg::ST_ENABLED;
					go          = 1'b1;
					dis_after_n = 1'b0;
					code        = crsf_pkg::RC_ACK;
				end else begin
					code = crsf_pkg::RC_OOS;
					len  = 4'd1;
				end
			end
			crsf_pkg::OP_RCANCEL: begin
				code = (st_q == crsf_pkg::ST_ENABLED) ? crsf_pkg::RC_CANCEL : crsf_pkg::RC_OOS;
				len  = 4'd1;
			end
			crsf_pkg::OP_ID: begin
				code = crsf_pkg::RC_PERIPH;
			end
			crsf_pkg::OP_FUNDS: begin
				funds_n    = pop_data.funds_value;
				end_pend_n = 1'b1;
				code       = crsf_pkg::RC_NONE;
			end
			default: begin
				code = crsf_pkg::RC_NONE;
			end
		endcase
		st_n = (go && target != st_q && crsf_pkg::move_allowed(st_q, target)) ? target : st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= crsf_pkg::ST_INACTIVE;
			cfg_seen_q  <= 1'b0;
			prc_seen_q  <= 1'b0;
			end_pend_q  <= 1'b0;
			dis_after_q <= 1'b0;
			funds_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				st_q        <= st_n;
				cfg_seen_q  <= cfg_seen_n;
				prc_seen_q  <= prc_seen_n;
				end_pend_q  <= end_pend_n;
				dis_after_q <= dis_after_n;
				funds_q     <= funds_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.response_code   <= code;
			rsp_q.response_length <= len;
			rsp_q.payload         <= payload;
			rsp_q.session_state   <= st_n;
			rsp_q.funds_now       <= funds_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign rsp      = rsp_q;

	a_state_only_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(st_q))
		else $error("Session state changed without a command being executed.");

	a_vend_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(take && st_q != crsf_pkg::ST_VEND && st_n == crsf_pkg::ST_VEND)
			|-> (st_q == crsf_pkg::ST_IDLE && pop_data.op == crsf_pkg::OP_VREQ))
		else $error("Vend state entered other than by an approved vend request.");

	a_funds_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(take && pop_data.op == crsf_pkg::OP_FUNDS)
			|=> (end_pend_q && funds_q == $past(pop_data.funds_value)))
		else $error("Funds event did not store funds and mark the session end request.");

	a_response_mirrors_state: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (rsp_q.session_state == st_q && rsp_q.funds_now == funds_q))
		else $error("Response state fields differ from the held session state.");

endmodule
